// ----- src/sha256_pkg.sv -----
// Shared types, constants and round functions for the SHA-256 byte stream hasher.
package sha256_pkg;

    localparam int BLOCK_BYTES = 64;
    localparam int ROUNDS      = 64;
    localparam int HASH_WORDS  = 8;
    localparam int PAD_LIMIT   = 56;

    typedef struct packed {
        logic [7:0] message_byte;
        logic       byte_present;
        logic       end_of_message;
    } in_word_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } out_word_t;

    typedef logic [31:0] hash_t [HASH_WORDS];

    typedef struct packed {
        logic start;
        logic init_hash;
    } core_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } core_stat_t;

    localparam logic [31:0] INIT_HASH [HASH_WORDS] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    localparam logic [31:0] ROUND_K [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

endpackage

// ----- src/sha256_byte_stream_hasher.sv -----
// SHA-256 byte stream hasher top level: byte buffer, padding sequencer, digest output.
//
// Input channel in_valid/in_ready carries one word: an optional message byte and an
// end-of-message mark. Output channel out_valid/out_ready carries the eight digest
// words in order, index 0 first, last_word set on index 7.
// A byte that does not fill the block is taken without waiting on the round unit.
// A byte that fills the block starts the shared round unit: a start step, 64 rounds,
// one fold and a step to see it done, with in_ready low throughout.
// End of message adds one padded block (two when 56 or more bytes are buffered),
// each run like a full block after a padding step, then eight output words at one
// per cycle while out_ready is high.
// When the receiver stalls, the current word holds and no new input is taken
// until all eight words are delivered. The hash then reloads its initial value.
// Reset clears the byte count and bit count and sets the hash to its initial value;
// the block buffer needs no clearing since padding writes every entry that is read.
module sha256_byte_stream_hasher
    import sha256_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_word_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_word_t out_data
);

    typedef enum logic [2:0] {ST_IDLE, ST_ABSORB, ST_PAD, ST_LEN, ST_OUT} state_t;

    state_t       state_reg;
    logic [31:0]  buf_reg [BLOCK_BYTES / 4];
    logic [5:0]   count_reg;
    logic [63:0]  bits_reg;
    logic         fin_reg;
    logic [2:0]   idx_reg;
    logic         wait_reg;
    core_ctrl_t   ctrl;
    core_stat_t   stat;
    hash_t        hash;
    logic [511:0] block;

    always_comb
    begin
        for (int i = 0; i < BLOCK_BYTES / 4; i++)
        begin
            block[511 - 32 * i -: 32] = buf_reg[i];
        end
    end

    sha256_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl),
        .block (block),
        .stat  (stat),
        .hash  (hash)
    );

    assign in_ready = (state_reg == ST_IDLE) && !fin_reg;
    assign out_valid = (state_reg == ST_OUT);
    assign out_data.digest_word = hash[idx_reg];
    assign out_data.word_index  = idx_reg;
    assign out_data.last_word   = (idx_reg == 3'd7);

    always_comb
    begin
        ctrl = '0;
        if (state_reg == ST_OUT && out_ready && idx_reg == 3'd7)
        begin
            ctrl.init_hash = 1'b1;
        end
        if (!wait_reg && (state_reg == ST_ABSORB || state_reg == ST_PAD
            || state_reg == ST_LEN))
        begin
            ctrl.start = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready && in_data.byte_present)
        begin
            buf_reg[count_reg[5:2]][{~count_reg[1:0], 3'b000} +: 8] <= in_data.message_byte;
        end
        if (state_reg == ST_IDLE && fin_reg)
        begin
            for (int w = 0; w < BLOCK_BYTES / 4; w++)
            begin
                for (int l = 0; l < 4; l++)
                begin
                    if (6'(4 * w + l) == count_reg)
                    begin
                        buf_reg[4'(w)][24 - 8 * l +: 8] <= 8'h80;
                    end
                    else if (6'(4 * w + l) > count_reg)
                    begin
                        buf_reg[4'(w)][24 - 8 * l +: 8] <= 8'h00;
                    end
                end
            end
            if (count_reg < 6'(PAD_LIMIT))
            begin
                buf_reg[PAD_LIMIT / 4]     <= bits_reg[63:32];
                buf_reg[PAD_LIMIT / 4 + 1] <= bits_reg[31:0];
            end
        end
        if (state_reg == ST_PAD && wait_reg && stat.done)
        begin
            // length-only block after overflow pad
            for (int w = 0; w < PAD_LIMIT / 4; w++)
            begin
                buf_reg[4'(w)] <= '0;
            end
            buf_reg[PAD_LIMIT / 4]     <= bits_reg[63:32];
            buf_reg[PAD_LIMIT / 4 + 1] <= bits_reg[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            bits_reg  <= '0;
            fin_reg   <= 1'b0;
            idx_reg   <= '0;
            wait_reg  <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (fin_reg)
                    begin
                        // buffer now padded
                        wait_reg <= 1'b0;
                        if (count_reg < 6'(PAD_LIMIT))
                        begin
                            state_reg <= ST_LEN;
                            fin_reg   <= 1'b1;
                        end
                        else
                        begin
                            state_reg <= ST_PAD;
                            fin_reg   <= 1'b0;
                        end
                    end
                    else if (in_valid)
                    begin
                        if (in_data.byte_present)
                        begin
                            count_reg <= count_reg + 6'd1;
                            bits_reg  <= bits_reg + 64'd8;
                        end
                        if (in_data.byte_present && count_reg == 6'(BLOCK_BYTES - 1))
                        begin
                            state_reg <= ST_ABSORB;
                            wait_reg  <= 1'b0;
                            fin_reg   <= in_data.end_of_message;
                        end
                        else
                        begin
                            fin_reg <= in_data.end_of_message;
                        end
                    end
                end
                ST_ABSORB:
                begin
                    wait_reg <= 1'b1;
                    if (wait_reg && stat.done)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_PAD:
                begin
                    wait_reg <= 1'b1;
                    if (wait_reg && stat.done)
                    begin
                        state_reg <= ST_LEN;
                        wait_reg  <= 1'b0;
                    end
                end
                ST_LEN:
                begin
                    wait_reg <= 1'b1;
                    fin_reg  <= 1'b1;
                    if (wait_reg && stat.done)
                    begin
                        state_reg <= ST_OUT;
                        idx_reg   <= '0;
                        fin_reg   <= 1'b0;
                    end
                end
                ST_OUT:
                begin
                    if (out_ready)
                    begin
                        idx_reg <= idx_reg + 3'd1;
                        if (idx_reg == 3'd7)
                        begin
                            state_reg <= ST_IDLE;
                            count_reg <= '0;
                            bits_reg  <= '0;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- src/sha256_core.sv -----
// Iterative compression: one round per cycle with a rolling 16-word schedule.
module sha256_core
    import sha256_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  core_ctrl_t   ctrl,
    input  logic [511:0] block,
    output core_stat_t   stat,
    output hash_t        hash
);

    hash_t       hash_reg;
    logic [31:0] v_reg [HASH_WORDS];
    logic [31:0] w_reg [16];
    logic [5:0]  round_reg;
    logic        busy_reg;
    logic        done_reg;

    logic [31:0] big0, big1, ch, maj, t1, t2, s0, s1, w_new;

    always_comb
    begin
        big1  = rotr(v_reg[4], 6) ^ rotr(v_reg[4], 11) ^ rotr(v_reg[4], 25);
        ch    = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        t1    = v_reg[7] + big1 + ch + ROUND_K[round_reg] + w_reg[0];
        big0  = rotr(v_reg[0], 2) ^ rotr(v_reg[0], 13) ^ rotr(v_reg[0], 22);
        maj   = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t2    = big0 + maj;
        s0    = rotr(w_reg[1], 7) ^ rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
        s1    = rotr(w_reg[14], 17) ^ rotr(w_reg[14], 19) ^ (w_reg[14] >> 10);
        w_new = s1 + w_reg[9] + s0 + w_reg[0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg  <= INIT_HASH;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            round_reg <= '0;
            for (int i = 0; i < HASH_WORDS; i++)
            begin
                v_reg[i] <= '0;
            end
            for (int i = 0; i < 16; i++)
            begin
                w_reg[i] <= '0;
            end
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctrl.init_hash)
            begin
                hash_reg <= INIT_HASH;
            end
            if (ctrl.start)
            begin
                busy_reg  <= 1'b1;
                round_reg <= '0;
                for (int i = 0; i < HASH_WORDS; i++)
                begin
                    v_reg[i] <= hash_reg[i];
                end
                for (int i = 0; i < 16; i++)
                begin
                    w_reg[i] <= block[511 - 32 * i -: 32];
                end
            end
            else if (busy_reg)
            begin
                for (int i = 0; i < 15; i++)
                begin
                    w_reg[i] <= w_reg[i + 1];
                end
                w_reg[15] <= w_new;
                v_reg[7]  <= v_reg[6];
                v_reg[6]  <= v_reg[5];
                v_reg[5]  <= v_reg[4];
                v_reg[4]  <= v_reg[3] + t1;
                v_reg[3]  <= v_reg[2];
                v_reg[2]  <= v_reg[1];
                v_reg[1]  <= v_reg[0];
                v_reg[0]  <= t1 + t2;
                if (round_reg == 6'(ROUNDS - 1))
                begin
                    busy_reg <= 1'b0;
                end
                else
                begin
                    round_reg <= round_reg + 6'd1;
                end
            end
            else if (!done_reg && round_reg == 6'(ROUNDS - 1))
            begin
                // fold working vars once after last round
                for (int i = 0; i < HASH_WORDS; i++)
                begin
                    hash_reg[i] <= hash_reg[i] + v_reg[i];
                end
                done_reg  <= 1'b1;
                round_reg <= '0;
            end
        end
    end

    assign stat.busy = busy_reg || (round_reg == 6'(ROUNDS - 1));
    assign stat.done = done_reg;
    assign hash      = hash_reg;

endmodule

// ----- src/sha256_checker.sv -----
// Port-level checks for the SHA-256 byte stream hasher, bound to the top level.
module sha256_checker
    import sha256_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_ready,
    input logic      out_valid,
    input logic      out_ready,
    input out_word_t out_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("digest word changed while stalled");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(out_valid && in_ready))
        else $error("input taken during digest output");

    a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_data.last_word
        |=> out_valid && out_data.word_index == $past(out_data.word_index) + 3'd1)
        else $error("digest index skipped");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && out_data.last_word |=> !out_valid)
        else $error("output after last word");

endmodule

bind sha256_byte_stream_hasher sha256_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

// ----- sim/tb.sv -----
// Testbench for the SHA-256 byte stream hasher: directed messages against a local hash model.
`timescale 1ns / 1ps

module tb;
    import sha256_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 200;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_word_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_word_t out_data;

    sha256_byte_stream_hasher u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    localparam logic [31:0] K_TAB [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

    localparam logic [31:0] H_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    logic [31:0] hash_st [8];
    logic [7:0]  blk [64];
    logic [5:0]  blk_fill;
    logic [63:0] bit_len;

    out_word_t digest_q[$];

    int  errors;
    int  words_seen;
    int  msgs_sent;
    int  bytes_sent;
    int  idle_pct;
    bit  hold_out;
    int  hold_cycles;
    int  quiet;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic [31:0] ror(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic compress();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] t1;
        logic [31:0] t2;
        for (int r = 0; r < 16; r++)
            w[r] = {blk[4*r], blk[4*r+1], blk[4*r+2], blk[4*r+3]};
        for (int r = 16; r < 64; r++)
            w[r] = (ror(w[r-2], 17) ^ ror(w[r-2], 19) ^ (w[r-2] >> 10)) + w[r-7]
                 + (ror(w[r-15], 7) ^ ror(w[r-15], 18) ^ (w[r-15] >> 3)) + w[r-16];
        v = hash_st;
        for (int r = 0; r < 64; r++)
        begin
            t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + K_TAB[r] + w[r];
            t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int r = 0; r < 8; r++)
            hash_st[r] = hash_st[r] + v[r];
    endtask

    task automatic hash_absorb(input in_word_t item);
        int i;
        out_word_t o;
        if (item.byte_present)
        begin
            blk[blk_fill] = item.message_byte;
            blk_fill = blk_fill + 6'd1;
            bit_len = bit_len + 64'd8;
            if (blk_fill == 6'd0)
                compress();
        end
        if (!item.end_of_message)
            return;
        i = blk_fill;
        blk[i] = 8'h80;
        i++;
        if (i > 56)
        begin
            while (i < 64) begin blk[i] = 8'h00; i++; end
            compress();
            i = 0;
        end
        while (i < 56) begin blk[i] = 8'h00; i++; end
        for (int j = 0; j < 8; j++)
            blk[56+j] = bit_len[63-8*j -: 8];
        compress();
        for (int j = 0; j < 8; j++)
        begin
            o.digest_word = hash_st[j];
            o.word_index  = 3'(j);
            o.last_word   = (j == 7);
            digest_q.push_back(o);
        end
        hash_st  = H_INIT;
        blk_fill = '0;
        bit_len  = '0;
        msgs_sent++;
    endtask

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        errors++;
    endtask

    task automatic send_word(input logic [7:0] b, input bit present, input bit last);
        in_word_t item;
        item.message_byte   = b;
        item.byte_present   = present;
        item.end_of_message = last;
        if (idle_pct > 0 && $urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while (idle_pct > 0 && $urandom_range(99) < idle_pct)
                @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        hash_absorb(item);
        if (present)
            bytes_sent++;
    endtask

    task automatic send_msg(input int len, input bit end_with_byte);
        for (int i = 0; i < len; i++)
            send_word(8'($urandom), 1'b1, end_with_byte && i == len - 1);
        if (!end_with_byte || len == 0)
            send_word(8'($urandom), 1'b0, 1'b1);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (digest_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_known_vectors();
        // empty message, then "abc" with an empty word inside
        send_word(8'hff, 1'b0, 1'b1);
        send_word(8'h61, 1'b1, 1'b0);
        send_word(8'h00, 1'b0, 1'b0);
        send_word(8'h62, 1'b1, 1'b0);
        send_word(8'h63, 1'b1, 1'b1);
        wait_drained();
    endtask

    task automatic test_pad_boundaries();
        // overflow pad, then a full block that ends the message, with no idling
        send_msg(56, 1'b1);
        idle_pct = 0;
        send_msg(64, 1'b1);
        idle_pct = 29;
        wait_drained();
    endtask

    task automatic test_backpressure();
        // hold the output long while input keeps coming
        hold_cycles = 600;
        hold_out = 1'b1;
        send_msg(1, 1'b1);
        send_msg(1, 1'b1);
        wait_drained();
    endtask

    always @(posedge clk)
    begin
        if (hold_out && hold_cycles > 0)
        begin
            out_ready   <= 1'b0;
            hold_cycles <= hold_cycles - 1;
            if (hold_cycles == 1)
                hold_out <= 1'b0;
        end
        else
            out_ready <= (idle_pct == 0) ? 1'b1 : ($urandom_range(99) >= idle_pct);
    end

    always @(posedge clk)
    begin
        out_word_t want;
        if (rst_n && out_valid && out_ready)
        begin
            words_seen++;
            if (digest_q.size() == 0)
            begin
                report("unexpected digest_word", out_data.digest_word, 32'h0);
            end
            else
            begin
                want = digest_q.pop_front();
                if (out_data.digest_word !== want.digest_word)
                    report("digest_word", out_data.digest_word, want.digest_word);
                if (out_data.word_index !== want.word_index)
                    report("word_index", 32'(out_data.word_index), 32'(want.word_index));
                if (out_data.last_word !== want.last_word)
                    report("last_word", 32'(out_data.last_word), 32'(want.last_word));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= WATCHDOG_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        clk         = 1'b0;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_data     = '0;
        out_ready   = 1'b0;
        hold_out    = 1'b0;
        hold_cycles = 0;
        quiet       = 0;
        errors      = 0;
        words_seen  = 0;
        msgs_sent   = 0;
        bytes_sent  = 0;
        idle_pct    = 29;
        hash_st     = H_INIT;
        blk_fill    = '0;
        bit_len     = '0;
        for (int i = 0; i < 64; i++)
            blk[i] = 8'h00;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_known_vectors();
        test_pad_boundaries();
        test_backpressure();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("covered %0d messages, %0d bytes, %0d digest words checked",
                 msgs_sent, bytes_sent, words_seen);
        $display("including empty and padded-over messages, a full final block and a long stall");
        if (errors == 0 && digest_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
